// ===== rtl/core/rcap_pkg.sv =====
// rcap_pkg: shared types, constants and saturating helpers for the ray/capsule pipeline
// depends on nothing; imported by every module under rtl/core
`default_nettype none
package rcap_pkg;

    typedef logic signed [63:0] q64_t;
    typedef logic signed [31:0] q32_t;
    typedef q64_t [2:0] vec_t;

    localparam q64_t Q_MAX   = 64'sh7fff_ffff_ffff_ffff;
    localparam q64_t Q_MIN   = 64'sh8000_0000_0000_0000;
    localparam q64_t Q32_MAX = 64'sd2147483647;
    localparam q64_t Q32_MIN = -64'sd2147483648;

    // multiplier pipeline stages: input, partial products, sum, saturate
    localparam int MUL_LAT = 4;

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    typedef struct packed {
        q32_t ray_origin_x;
        q32_t ray_origin_y;
        q32_t ray_origin_z;
        q32_t ray_dir_x;
        q32_t ray_dir_y;
        q32_t ray_dir_z;
        q32_t center_x;
        q32_t center_y;
        q32_t center_z;
        q32_t axis_x;
        q32_t axis_y;
        q32_t axis_z;
    } ray_word_t;

    typedef struct packed {
        logic hit_flag;
        q32_t ray_param;
        q32_t hit_x;
        q32_t hit_y;
        q32_t hit_z;
    } hit_word_t;

    // per-ray context that travels alongside the arithmetic
    typedef struct packed {
        logic en;
        logic hok;
        logic chok;
        logic body;
        logic hit;
        vec_t ro;
        vec_t rd;
        vec_t ce;
        vec_t ax;
        vec_t pa;
        vec_t pb;
        vec_t oa;
        vec_t ob;
        vec_t oc;
        q64_t baba;
        q64_t bard;
        q64_t baoa;
        q64_t rr;
        q64_t a;
        q64_t b;
        q64_t tb;
        q64_t cb;
        q64_t cc;
        q64_t tq;
    } ray_ctx_t;

    function automatic q64_t qadd(input q64_t x, input q64_t y);
        q64_t s;
        s = x + y;
        if (x[63] == y[63] && s[63] != x[63])
            s = x[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic q64_t qsub(input q64_t x, input q64_t y);
        q64_t s;
        s = x - y;
        if (x[63] != y[63] && s[63] != x[63])
            s = x[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    // halve, truncating toward zero
    function automatic q64_t q_half(input q64_t v);
        q64_t s;
        s = v[63] ? ((v + 64'sd1) >>> 1) : (v >>> 1);
        return s;
    endfunction

    function automatic q32_t sat32(input q64_t v);
        q32_t s;
        if (v > Q32_MAX)
            s = 32'sh7fff_ffff;
        else if (v < Q32_MIN)
            s = 32'sh8000_0000;
        else
            s = v[31:0];
        return s;
    endfunction

    // signed result from sign and magnitude, saturating
    function automatic q64_t from_mag(input logic neg, input logic [63:0] m, input logic ovf);
        q64_t s;
        if (!neg)
            s = (ovf || m[63]) ? Q_MAX : q64_t'(m);
        else
            s = (ovf || m[63]) ? Q_MIN : -q64_t'(m);
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ray_capsule_intersection.sv =====
// ray_capsule_intersection: top level, ray against capsule body and end caps
// depends on rcap_pkg, rcap_mul_phase, rcap_sqrt, rcap_div
//
//   channel  | signals                           | direction
//   ray      | ray_valid, ray_ready, ray         | in, one ray word per handshake
//   hit      | hit_valid, hit_ready, hit         | out, one hit word per ray
//   config   | cfg_write, cfg_index, cfg_data    | in, write only
//
// one ray enters per cycle when the pipeline advances; the latency is set by the multiplier,
// root and divider chains
// the whole pipeline advances whenever the output register is empty or being taken
// a stalled output freezes every stage, so nothing is lost or repeated
// reset clears valid bits and loads radius 1.0, height 2.0, enabled
`default_nettype none
module ray_capsule_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ray_valid,
    output logic                ray_ready,
    input  rcap_pkg::ray_word_t ray,
    output logic                hit_valid,
    input  logic                hit_ready,
    output rcap_pkg::hit_word_t hit,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);
    import rcap_pkg::*;

    logic [30:0] radius_reg, height_reg;
    logic        enabled_reg;
    logic        en;

    logic        hit_valid_reg;
    hit_word_t   hit_reg, hit_next;

    ray_ctx_t c0, c1, g1_next, g1_ctx_reg, c2, c2o, c3, c3o, c4, c4o;
    ray_ctx_t c5, c5o, c6, c6o, c7, c7o, c8, c8o, c9, c9o, c10, c10o, c11, c11o;
    logic     v1, g1_vld_reg, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;

    q64_t m1_a [3], m1_b [3], m1_p [3];
    q64_t m2_a [16], m2_b [16], m2_p [16];
    q64_t m3_a [6], m3_b [6], m3_p [6];
    q64_t m4_a [2], m4_b [2], m4_p [2];
    q64_t m5_a [1], m5_b [1], m5_p [1];
    q64_t m6_a [6], m6_b [6], m6_p [6];
    q64_t m7_a [1], m7_b [1], m7_p [1];
    q64_t m8_a [3], m8_b [3], m8_p [3];
    q64_t h_rad, s1_root, div_num, div_quo, ch_rad, s2_root;

    assign en        = !hit_valid_reg || hit_ready;
    assign ray_ready = en;
    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 31'd65536;
            height_reg  <= 31'd131072;
            enabled_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg  <= cfg_data;
                REG_HEIGHT: height_reg  <= cfg_data;
                REG_ENABLE: enabled_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // axis scaled by the height
    always_comb
    begin
        c0       = '0;
        c0.en    = enabled_reg;
        c0.ro[0] = 64'(ray.ray_origin_x);
        c0.ro[1] = 64'(ray.ray_origin_y);
        c0.ro[2] = 64'(ray.ray_origin_z);
        c0.rd[0] = 64'(ray.ray_dir_x);
        c0.rd[1] = 64'(ray.ray_dir_y);
        c0.rd[2] = 64'(ray.ray_dir_z);
        c0.ce[0] = 64'(ray.center_x);
        c0.ce[1] = 64'(ray.center_y);
        c0.ce[2] = 64'(ray.center_z);
        c0.ax[0] = 64'(ray.axis_x);
        c0.ax[1] = 64'(ray.axis_y);
        c0.ax[2] = 64'(ray.axis_z);
        for (int k = 0; k < 3; k++)
        begin
            m1_a[k] = c0.ax[k];
            m1_b[k] = q64_t'({33'd0, height_reg});
        end
    end

    rcap_mul_phase #(.N(3), .FRAC_BITS(FRAC_BITS)) u_m1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(ray_valid), .in_ctx(c0),
        .a(m1_a), .b(m1_b), .out_vld(v1), .out_ctx(c1), .p(m1_p)
    );

    // cap centers
    always_comb
    begin
        q64_t half;
        g1_next = c1;
        for (int k = 0; k < 3; k++)
        begin
            half          = q_half(m1_p[k]);
            g1_next.pa[k] = qsub(c1.ce[k], half);
            g1_next.pb[k] = qadd(c1.ce[k], half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g1_vld_reg <= 1'b0;
        else if (en)
            g1_vld_reg <= v1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            g1_ctx_reg <= g1_next;
    end

    always_comb
    begin
        vec_t ba;
        c2 = g1_ctx_reg;
        for (int k = 0; k < 3; k++)
        begin
            ba[k]          = qsub(g1_ctx_reg.pb[k], g1_ctx_reg.pa[k]);
            c2.oa[k]       = qsub(g1_ctx_reg.ro[k], g1_ctx_reg.pa[k]);
            c2.ob[k]       = qsub(g1_ctx_reg.ro[k], g1_ctx_reg.pb[k]);
            m2_a[k]        = ba[k];
            m2_b[k]        = ba[k];
            m2_a[3+k]      = ba[k];
            m2_b[3+k]      = g1_ctx_reg.rd[k];
            m2_a[6+k]      = ba[k];
            m2_b[6+k]      = c2.oa[k];
            m2_a[9+k]      = g1_ctx_reg.rd[k];
            m2_b[9+k]      = c2.oa[k];
            m2_a[12+k]     = c2.oa[k];
            m2_b[12+k]     = c2.oa[k];
        end
        m2_a[15] = q64_t'({33'd0, radius_reg});
        m2_b[15] = q64_t'({33'd0, radius_reg});
    end

    rcap_mul_phase #(.N(16), .FRAC_BITS(FRAC_BITS)) u_m2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(g1_vld_reg), .in_ctx(c2),
        .a(m2_a), .b(m2_b), .out_vld(v2), .out_ctx(c2o), .p(m2_p)
    );

    // dot products
    always_comb
    begin
        q64_t rdoa, oaoa;
        c3      = c2o;
        c3.baba = qadd(qadd(m2_p[0], m2_p[1]), m2_p[2]);
        c3.bard = qadd(qadd(m2_p[3], m2_p[4]), m2_p[5]);
        c3.baoa = qadd(qadd(m2_p[6], m2_p[7]), m2_p[8]);
        rdoa    = qadd(qadd(m2_p[9], m2_p[10]), m2_p[11]);
        oaoa    = qadd(qadd(m2_p[12], m2_p[13]), m2_p[14]);
        c3.rr   = m2_p[15];
        m3_a[0] = c3.bard; m3_b[0] = c3.bard;
        m3_a[1] = c3.baba; m3_b[1] = rdoa;
        m3_a[2] = c3.baoa; m3_b[2] = c3.bard;
        m3_a[3] = c3.baba; m3_b[3] = oaoa;
        m3_a[4] = c3.baoa; m3_b[4] = c3.baoa;
        m3_a[5] = c3.rr;   m3_b[5] = c3.baba;
    end

    rcap_mul_phase #(.N(6), .FRAC_BITS(FRAC_BITS)) u_m3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v2), .in_ctx(c3),
        .a(m3_a), .b(m3_b), .out_vld(v3), .out_ctx(c3o), .p(m3_p)
    );

    // quadratic coefficients
    always_comb
    begin
        q64_t cq;
        c4      = c3o;
        c4.a    = qsub(c3o.baba, m3_p[0]);
        c4.b    = qsub(m3_p[1], m3_p[2]);
        cq      = qsub(qsub(m3_p[3], m3_p[4]), m3_p[5]);
        m4_a[0] = c4.b; m4_b[0] = c4.b;
        m4_a[1] = c4.a; m4_b[1] = cq;
    end

    rcap_mul_phase #(.N(2), .FRAC_BITS(FRAC_BITS)) u_m4 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v3), .in_ctx(c4),
        .a(m4_a), .b(m4_b), .out_vld(v4), .out_ctx(c4o), .p(m4_p)
    );

    always_comb
    begin
        q64_t h;
        h      = qsub(m4_p[0], m4_p[1]);
        c5     = c4o;
        c5.hok = !h[63];
        h_rad  = h[63] ? '0 : h;
    end

    rcap_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_body (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v4), .in_ctx(c5),
        .rad(h_rad), .out_vld(v5), .out_ctx(c5o), .root(s1_root)
    );

    always_comb
    begin
        c6      = c5o;
        div_num = qsub(qsub('0, c5o.b), s1_root);
    end

    rcap_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v5), .in_ctx(c6),
        .num(div_num), .den(c5o.a), .out_vld(v6), .out_ctx(c6o), .quo(div_quo)
    );

    always_comb
    begin
        c7      = c6o;
        c7.tb   = div_quo;
        m5_a[0] = div_quo;
        m5_b[0] = c6o.bard;
    end

    rcap_mul_phase #(.N(1), .FRAC_BITS(FRAC_BITS)) u_m5 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v6), .in_ctx(c7),
        .a(m5_a), .b(m5_b), .out_vld(v7), .out_ctx(c7o), .p(m5_p)
    );

    // axial coordinate picks body or the nearer cap
    always_comb
    begin
        q64_t y;
        y       = qadd(c7o.baoa, m5_p[0]);
        c8      = c7o;
        c8.body = (y > 64'sd0) && (y < c7o.baba);
        c8.oc   = (y <= 64'sd0) ? c7o.oa : c7o.ob;
        for (int k = 0; k < 3; k++)
        begin
            m6_a[k]   = c7o.rd[k];
            m6_b[k]   = c8.oc[k];
            m6_a[3+k] = c8.oc[k];
            m6_b[3+k] = c8.oc[k];
        end
    end

    rcap_mul_phase #(.N(6), .FRAC_BITS(FRAC_BITS)) u_m6 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v7), .in_ctx(c8),
        .a(m6_a), .b(m6_b), .out_vld(v8), .out_ctx(c8o), .p(m6_p)
    );

    always_comb
    begin
        c9      = c8o;
        c9.cb   = qadd(qadd(m6_p[0], m6_p[1]), m6_p[2]);
        c9.cc   = qsub(qadd(qadd(m6_p[3], m6_p[4]), m6_p[5]), c8o.rr);
        m7_a[0] = c9.cb;
        m7_b[0] = c9.cb;
    end

    rcap_mul_phase #(.N(1), .FRAC_BITS(FRAC_BITS)) u_m7 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v8), .in_ctx(c9),
        .a(m7_a), .b(m7_b), .out_vld(v9), .out_ctx(c9o), .p(m7_p)
    );

    always_comb
    begin
        q64_t ch;
        ch      = qsub(m7_p[0], c9o.cc);
        c10     = c9o;
        c10.chok = ch > 64'sd0;
        ch_rad  = (ch > 64'sd0) ? ch : '0;
    end

    rcap_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt_cap (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v9), .in_ctx(c10),
        .rad(ch_rad), .out_vld(v10), .out_ctx(c10o), .root(s2_root)
    );

    // final t, clamped to 32 bits before the hit point
    always_comb
    begin
        q64_t tcap, t;
        tcap    = qsub(qsub('0, c10o.cb), s2_root);
        t       = c10o.body ? c10o.tb : tcap;
        c11     = c10o;
        c11.hit = c10o.en && c10o.hok && (c10o.body || c10o.chok);
        c11.tq  = 64'(sat32(t));
        for (int k = 0; k < 3; k++)
        begin
            m8_a[k] = c10o.rd[k];
            m8_b[k] = c11.tq;
        end
    end

    rcap_mul_phase #(.N(3), .FRAC_BITS(FRAC_BITS)) u_m8 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v10), .in_ctx(c11),
        .a(m8_a), .b(m8_b), .out_vld(v11), .out_ctx(c11o), .p(m8_p)
    );

    always_comb
    begin
        hit_next = '0;
        if (c11o.hit)
        begin
            hit_next.hit_flag  = 1'b1;
            hit_next.ray_param = c11o.tq[31:0];
            hit_next.hit_x     = sat32(qadd(c11o.ro[0], m8_p[0]));
            hit_next.hit_y     = sat32(qadd(c11o.ro[1], m8_p[1]));
            hit_next.hit_z     = sat32(qadd(c11o.ro[2], m8_p[2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_valid_reg <= 1'b0;
        else if (en)
            hit_valid_reg <= v11;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit.hit_flag |-> hit.ray_param == '0 && hit.hit_x == '0
            && hit.hit_y == '0 && hit.hit_z == '0)
        else $error("miss word carries nonzero fields");

    a_hit_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        v11 && c11o.hit |-> c11o.en && c11o.hok)
        else $error("hit without enable or real body root");

    a_body_t: assert property (@(posedge clk) disable iff (!rst_n)
        v11 && c11o.hit && c11o.body |-> c11o.tq == 64'(sat32(c11o.tb)))
        else $error("body hit does not use body t");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v11) && $stable(c11o.tq))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rcap_qmul.sv =====
// rcap_qmul: pipelined saturating fixed-point multiply, four stages
// built from 32x32 partial products; uses rcap_pkg
`default_nettype none
module rcap_qmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          en,
    input  rcap_pkg::q64_t a,
    input  rcap_pkg::q64_t b,
    output rcap_pkg::q64_t p
);
    import rcap_pkg::*;

    q64_t         a_reg, b_reg;
    logic [63:0]  ma, mb;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic         neg1_reg, neg2_reg;
    logic [127:0] prod_reg;
    q64_t         p_reg;
    logic [63:0]  r;
    logic         ovf;

    always_comb
    begin
        ma  = a_reg[63] ? 64'(-a_reg) : 64'(a_reg);
        mb  = b_reg[63] ? 64'(-b_reg) : 64'(b_reg);
        r   = prod_reg[63+FRAC_BITS:FRAC_BITS];
        ovf = |prod_reg[127:64+FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            b_reg    <= b;
            p00_reg  <= ma[31:0]  * mb[31:0];
            p01_reg  <= ma[31:0]  * mb[63:32];
            p10_reg  <= ma[63:32] * mb[31:0];
            p11_reg  <= ma[63:32] * mb[63:32];
            neg1_reg <= a_reg[63] ^ b_reg[63];
            prod_reg <= {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0}
                      + {32'd0, p10_reg, 32'd0} + {64'd0, p00_reg};
            neg2_reg <= neg1_reg;
            p_reg    <= from_mag(neg2_reg, r, ovf);
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rcap_mul_phase.sv =====
// rcap_mul_phase: a bank of parallel multipliers with the ray context delayed alongside
// depends on rcap_pkg and rcap_qmul
`default_nettype none
module rcap_mul_phase #(
    parameter int N         = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  rcap_pkg::ray_ctx_t in_ctx,
    input  rcap_pkg::q64_t     a [N],
    input  rcap_pkg::q64_t     b [N],
    output logic              out_vld,
    output rcap_pkg::ray_ctx_t out_ctx,
    output rcap_pkg::q64_t     p [N]
);
    import rcap_pkg::*;

    logic [MUL_LAT-1:0] vld_reg;
    ray_ctx_t           ctx_reg [MUL_LAT];

    for (genvar i = 0; i < N; i++)
    begin : g_mul
        rcap_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
            .clk (clk),
            .en  (en),
            .a   (a[i]),
            .b   (b[i]),
            .p   (p[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[MUL_LAT-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int i = 1; i < MUL_LAT; i++)
                ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    assign out_vld = vld_reg[MUL_LAT-1];
    assign out_ctx = ctx_reg[MUL_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/core/rcap_sqrt.sv =====
// rcap_sqrt: pipelined floor square root in fixed point, one root bit per stage
// depends on rcap_pkg
`default_nettype none
module rcap_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  rcap_pkg::ray_ctx_t in_ctx,
    input  rcap_pkg::q64_t     rad,
    output logic              out_vld,
    output rcap_pkg::ray_ctx_t out_ctx,
    output rcap_pkg::q64_t     root
);
    import rcap_pkg::*;

    localparam int W  = 64 + FRAC_BITS;
    localparam int RB = (W + 1) / 2;
    localparam int WE = 2 * RB;

    logic [WE-1:0] x_reg   [RB+1];
    logic [RB+1:0] rem_reg [RB+1];
    logic [RB-1:0] q_reg   [RB+1];
    ray_ctx_t      ctx_reg [RB+1];
    logic [RB:0]   vld_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= WE'({rad, {FRAC_BITS{1'b0}}});
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            ctx_reg[0] <= in_ctx;
        end
    end

    for (genvar i = 0; i < RB; i++)
    begin : g_step
        logic [RB+2:0] cur, trial;
        logic          ge;

        always_comb
        begin
            cur   = {rem_reg[i][RB:0], x_reg[i][WE-1:WE-2]};
            trial = {1'b0, q_reg[i], 2'b01};
            ge    = cur >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? (RB+2)'(cur - trial) : (RB+2)'(cur);
                q_reg[i+1]   <= {q_reg[i][RB-2:0], ge};
                x_reg[i+1]   <= {x_reg[i][WE-3:0], 2'b00};
                ctx_reg[i+1] <= ctx_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RB-1:0], in_vld};
    end

    assign out_vld = vld_reg[RB];
    assign out_ctx = ctx_reg[RB];
    assign root    = q64_t'(q_reg[RB]);

endmodule
`default_nettype wire

// ===== rtl/core/rcap_div.sv =====
// rcap_div: pipelined restoring divider for saturating fixed-point quotients
// one quotient bit per stage; depends on rcap_pkg
`default_nettype none
module rcap_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  rcap_pkg::ray_ctx_t in_ctx,
    input  rcap_pkg::q64_t     num,
    input  rcap_pkg::q64_t     den,
    output logic              out_vld,
    output rcap_pkg::ray_ctx_t out_ctx,
    output rcap_pkg::q64_t     quo
);
    import rcap_pkg::*;

    localparam int W = 64 + FRAC_BITS;

    typedef struct packed {
        logic neg;
        logic dz;
        logic nz;
        logic nneg;
    } div_sign_t;

    logic [W-1:0]  x_reg   [W+1];
    logic [63:0]   rem_reg [W+1];
    logic [63:0]   ud_reg  [W+1];
    div_sign_t     sg_reg  [W+1];
    ray_ctx_t      ctx_reg [W+1];
    logic [W:0]    vld_reg;
    logic [63:0]   un, ud;
    div_sign_t     sg;
    div_sign_t     sg_last;
    logic [W-1:0]  q_last;

    always_comb
    begin
        un      = num[63] ? 64'(-num) : 64'(num);
        ud      = den[63] ? 64'(-den) : 64'(den);
        sg.neg  = num[63] ^ den[63];
        sg.dz   = den == '0;
        sg.nz   = num == '0;
        sg.nneg = num[63];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= {un, {FRAC_BITS{1'b0}}};
            rem_reg[0] <= '0;
            ud_reg[0]  <= ud;
            sg_reg[0]  <= sg;
            ctx_reg[0] <= in_ctx;
        end
    end

    for (genvar i = 0; i < W; i++)
    begin : g_step
        logic [64:0] cur;
        logic        ge;

        always_comb
        begin
            cur = {rem_reg[i], x_reg[i][W-1]};
            ge  = cur >= {1'b0, ud_reg[i]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? 64'(cur - {1'b0, ud_reg[i]}) : cur[63:0];
                x_reg[i+1]   <= {x_reg[i][W-2:0], ge};
                ud_reg[i+1]  <= ud_reg[i];
                sg_reg[i+1]  <= sg_reg[i];
                ctx_reg[i+1] <= ctx_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[W-1:0], in_vld};
    end

    // zero divisor: zero for a zero numerator, else largest magnitude with the numerator's sign
    always_comb
    begin
        sg_last = sg_reg[W];
        q_last  = x_reg[W];
        if (sg_last.dz)
            quo = sg_last.nz ? '0 : (sg_last.nneg ? Q_MIN : Q_MAX);
        else
            quo = from_mag(sg_last.neg, q_last[63:0], |q_last[W-1:64]);
    end

    assign out_vld = vld_reg[W];
    assign out_ctx = ctx_reg[W];

endmodule
`default_nettype wire
